[sv/trp_pkg.sv]
package trp_pkg;

  // Table size and the widths that follow from it.
  localparam int TASKS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  // Operation codes; codes 6 and 7 behave as a read.
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_REGISTER = 3'd1;
  localparam logic [2:0] OP_SWITCH_IN  = 3'd2;
  localparam logic [2:0] OP_SWITCH_OUT = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADIDX = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_LOAD,
    ST_SLICE,
    ST_TOTAL,
    ST_WIN,
    ST_INC,
    ST_WB,
    ST_ELAP,
    ST_WELAP
  } state_t;

  // One request.
  typedef struct packed {
    logic [2:0]       operation;
    logic [IDX_W-1:0] task_index;
    logic             core;
    logic [63:0]      timestamp;
  } req_t;

  // One result.
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] assigned_index;
    logic [CNT_W-1:0] registered_count;
    logic [63:0]      total_run_time;
    logic [31:0]      window_run_time;
    logic [31:0]      core0_starts;
    logic [31:0]      core1_starts;
    logic             is_running;
    logic [63:0]      total_elapsed;
    logic [31:0]      window_elapsed;
  } rsp_t;

  // Slice bookkeeping of one task, kept across window ticks.
  typedef struct packed {
    logic [63:0] slice_start;
    logic [63:0] run_total;
    logic        running;
  } rec_long_t;

  // Per-window counters of one task, cleared by a window tick.
  typedef struct packed {
    logic [31:0] run_window;
    logic [31:0] starts0;
    logic [31:0] starts1;
  } rec_win_t;

endpackage

[sv/task_runtime_profiler.sv]
// Channel  Signals                       Direction  Payload
// in       in_valid, in_ready, in_data    request    trp_pkg::req_t
// out      out_valid, out_ready, out_data result     trp_pkg::rsp_t
//
// A start, tick or read of a registered task passes the read, load and elapsed-time
// states; a switch in adds the increment and write-back states, a switch out the
// slice, total, window and write-back states. A register goes straight to write-back,
// and a request with an unregistered index or a refused register straight to the
// elapsed-time states. The next request is taken in the cycle after the result is
// loaded. A window tick first sweeps the per-window counters. One 64-bit adder serves
// every subtraction and sum in turn, and the record memories have one port. Reset
// clears the task count, origin and window start; registering a task clears its record.
// A stalled result waits in the output register while the next request is taken.
module task_runtime_profiler (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  trp_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output trp_pkg::rsp_t  out_data
);

  // Record memories.
  trp_pkg::rec_long_t mem_long [trp_pkg::TASKS];
  trp_pkg::rec_win_t  mem_win  [trp_pkg::TASKS];
  trp_pkg::rec_long_t rd_long;
  trp_pkg::rec_win_t  rd_win;

  trp_pkg::state_t state, state_next;
  trp_pkg::req_t   req;

  logic                        show;
  logic [1:0]                  status;
  logic [trp_pkg::IDX_W-1:0]   sel;
  logic [trp_pkg::CNT_W-1:0]   sw_cnt;
  logic [trp_pkg::CNT_W-1:0]   task_total;
  logic [63:0]                 origin_time;
  logic [63:0]                 window_start;

  // Working copy of the addressed record.
  logic [63:0] w_start;
  logic [63:0] w_total;
  logic [31:0] w_window;
  logic [31:0] w_s0;
  logic [31:0] w_s1;
  logic        w_run;
  logic [63:0] slice;
  logic [63:0] tot_elapsed;

  // Shared adder.
  logic [63:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  // Memory control.
  logic                      long_we, win_we, rd_en;
  logic [trp_pkg::IDX_W-1:0] mem_addr;
  trp_pkg::rec_long_t        long_wdata;
  trp_pkg::rec_win_t         win_wdata;

  // Request decode at acceptance.
  logic                      accept;
  logic                      in_is_reg, full, in_idx_ok, in_show, in_rec_op;
  logic [1:0]                in_status;
  logic [trp_pkg::IDX_W-1:0] in_sel;
  logic                      rsp_load;

  assign in_ready = (state == trp_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign full      = (task_total == trp_pkg::CNT_W'(trp_pkg::TASKS));
  assign in_is_reg = (in_data.operation == trp_pkg::OP_REGISTER);
  assign in_idx_ok = ({1'b0, in_data.task_index} < task_total);
  assign in_rec_op = (in_data.operation != trp_pkg::OP_START) && !in_is_reg &&
                     (in_data.operation != trp_pkg::OP_TICK);
  assign in_show   = in_is_reg ? !full : in_idx_ok;
  assign in_sel    = in_is_reg ? task_total[trp_pkg::IDX_W-1:0] : in_data.task_index;

  always_comb begin
    priority if (in_is_reg && full) begin
      in_status = trp_pkg::STATUS_FULL;
    end else if (in_rec_op && !in_idx_ok) begin
      in_status = trp_pkg::STATUS_BADIDX;
    end else begin
      in_status = trp_pkg::STATUS_OK;
    end
  end

  // The adder subtracts by adding the complement plus one.
  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {63'd0, alu_sub};

  // The result register is free when empty or being taken.
  assign rsp_load = (state == trp_pkg::ST_WELAP) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      trp_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_data.operation == trp_pkg::OP_TICK) begin
            state_next = trp_pkg::ST_SWEEP;
          end else if (in_show && in_is_reg) begin
            state_next = trp_pkg::ST_WB;
          end else if (in_show) begin
            state_next = trp_pkg::ST_READ;
          end else begin
            state_next = trp_pkg::ST_ELAP;
          end
        end
      end
      trp_pkg::ST_SWEEP: begin
        if (sw_cnt >= task_total) begin
          state_next = show ? trp_pkg::ST_READ : trp_pkg::ST_ELAP;
        end
      end
      trp_pkg::ST_READ:  state_next = trp_pkg::ST_LOAD;
      trp_pkg::ST_LOAD: begin
        priority if (req.operation == trp_pkg::OP_SWITCH_IN) begin
          state_next = trp_pkg::ST_INC;
        end else if (req.operation == trp_pkg::OP_SWITCH_OUT) begin
          state_next = trp_pkg::ST_SLICE;
        end else begin
          state_next = trp_pkg::ST_ELAP;
        end
      end
      trp_pkg::ST_SLICE: state_next = trp_pkg::ST_TOTAL;
      trp_pkg::ST_TOTAL: state_next = trp_pkg::ST_WIN;
      trp_pkg::ST_WIN:   state_next = trp_pkg::ST_WB;
      trp_pkg::ST_INC:   state_next = trp_pkg::ST_WB;
      trp_pkg::ST_WB:    state_next = trp_pkg::ST_ELAP;
      trp_pkg::ST_ELAP:  state_next = trp_pkg::ST_WELAP;
      trp_pkg::ST_WELAP: begin
        if (rsp_load) begin
          state_next = trp_pkg::ST_IDLE;
        end
      end
      default: state_next = trp_pkg::ST_IDLE;
    endcase
  end

  // Adder operands and memory controls per state.
  always_comb begin
    alu_a      = req.timestamp;
    alu_b      = 64'd0;
    alu_sub    = 1'b0;
    long_we    = 1'b0;
    win_we     = 1'b0;
    rd_en      = 1'b0;
    mem_addr   = sel;
    long_wdata = '{slice_start: w_start, run_total: w_total, running: w_run};
    win_wdata  = '{run_window: w_window, starts0: w_s0, starts1: w_s1};
    unique case (state)
      trp_pkg::ST_SWEEP: begin
        mem_addr  = sw_cnt[trp_pkg::IDX_W-1:0];
        win_we    = (sw_cnt < task_total);
        win_wdata = '0;
      end
      trp_pkg::ST_READ: rd_en = 1'b1;
      trp_pkg::ST_SLICE: begin
        alu_b   = w_start;
        alu_sub = 1'b1;
      end
      trp_pkg::ST_TOTAL: begin
        alu_a = w_total;
        alu_b = slice;
      end
      trp_pkg::ST_WIN: begin
        alu_a = {32'd0, w_window};
        alu_b = {32'd0, slice[31:0]};
      end
      trp_pkg::ST_INC: begin
        alu_a = {32'd0, (req.core ? w_s1 : w_s0)};
        alu_b = 64'd1;
      end
      trp_pkg::ST_WB: begin
        long_we = 1'b1;
        win_we  = 1'b1;
      end
      trp_pkg::ST_ELAP: begin
        alu_b   = origin_time;
        alu_sub = 1'b1;
      end
      trp_pkg::ST_WELAP: begin
        alu_b   = window_start;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Record memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (long_we) begin
      mem_long[mem_addr] <= long_wdata;
    end
    if (win_we) begin
      mem_win[mem_addr] <= win_wdata;
    end
    if (rd_en) begin
      rd_long <= mem_long[mem_addr];
      rd_win  <= mem_win[mem_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= trp_pkg::ST_IDLE;
      task_total   <= '0;
      origin_time  <= 64'd0;
      window_start <= 64'd0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_data.operation == trp_pkg::OP_START) begin
        origin_time  <= in_data.timestamp;
        window_start <= in_data.timestamp;
      end else if (accept && in_data.operation == trp_pkg::OP_TICK) begin
        window_start <= in_data.timestamp;
      end
      if (state == trp_pkg::ST_WB && req.operation == trp_pkg::OP_REGISTER) begin
        task_total <= task_total + trp_pkg::CNT_W'(1);
      end
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request context and the working record.
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= in_data;
      show     <= in_show;
      status   <= in_status;
      sel      <= in_sel;
      sw_cnt   <= '0;
      w_start  <= 64'd0;
      w_total  <= 64'd0;
      w_window <= 32'd0;
      w_s0     <= 32'd0;
      w_s1     <= 32'd0;
      w_run    <= 1'b0;
    end
    unique case (state)
      trp_pkg::ST_SWEEP: begin
        if (sw_cnt < task_total) begin
          sw_cnt <= sw_cnt + trp_pkg::CNT_W'(1);
        end
      end
      trp_pkg::ST_LOAD: begin
        w_start  <= rd_long.slice_start;
        w_total  <= rd_long.run_total;
        w_run    <= rd_long.running;
        w_window <= rd_win.run_window;
        w_s0     <= rd_win.starts0;
        w_s1     <= rd_win.starts1;
      end
      trp_pkg::ST_SLICE: slice <= alu_y;
      trp_pkg::ST_TOTAL: w_total <= alu_y;
      trp_pkg::ST_WIN: begin
        w_window <= alu_y[31:0];
        w_run    <= 1'b0;
      end
      trp_pkg::ST_INC: begin
        if (req.core) begin
          w_s1 <= alu_y[31:0];
        end else begin
          w_s0 <= alu_y[31:0];
        end
        w_start <= req.timestamp;
        w_run   <= 1'b1;
      end
      trp_pkg::ST_ELAP: tot_elapsed <= alu_y;
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_data.status           <= status;
      out_data.assigned_index   <= (show && req.operation == trp_pkg::OP_REGISTER) ?
                                   sel : '0;
      out_data.registered_count <= task_total;
      out_data.total_run_time   <= w_total;
      out_data.window_run_time  <= w_window;
      out_data.core0_starts     <= w_s0;
      out_data.core1_starts     <= w_s1;
      out_data.is_running       <= w_run;
      out_data.total_elapsed    <= tot_elapsed;
      out_data.window_elapsed   <= alu_y[31:0];
    end
  end

endmodule

[dv/profiler_checker.sv]
`timescale 1ns / 100ps

module profiler_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  trp_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  trp_pkg::rsp_t out_data,
  output int            pending,
  output int            mismatches
);

  // Shadow copy of the task table and the global timestamps.
  logic [63:0]               slice_t0    [trp_pkg::TASKS];
  logic [63:0]               busy_total  [trp_pkg::TASKS];
  logic [31:0]               busy_window [trp_pkg::TASKS];
  logic [31:0]               c0_count    [trp_pkg::TASKS];
  logic [31:0]               c1_count    [trp_pkg::TASKS];
  logic                      on_cpu      [trp_pkg::TASKS];
  logic [trp_pkg::CNT_W-1:0] task_count;
  logic [63:0]               origin_us;
  logic [63:0]               window_us;

  trp_pkg::rsp_t due_results [$];
  int            errs;

  function automatic void clear_slot(input int i);
    slice_t0[i]    = '0;
    busy_total[i]  = '0;
    busy_window[i] = '0;
    c0_count[i]    = '0;
    c1_count[i]    = '0;
    on_cpu[i]      = 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic trp_pkg::rsp_t profile_event(input trp_pkg::req_t ev);
    trp_pkg::rsp_t             r;
    logic                      show;
    logic                      known;
    logic [trp_pkg::IDX_W-1:0] sel;
    logic [63:0]               slice;
    logic [63:0]               delta;
    r     = '0;
    show  = 1'b0;
    sel   = ev.task_index;
    known = ({1'b0, ev.task_index} < task_count);
    case (ev.operation)
      trp_pkg::OP_START: begin
        origin_us = ev.timestamp;
        window_us = ev.timestamp;
        show      = known;
      end
      trp_pkg::OP_REGISTER: begin
        if (task_count < trp_pkg::TASKS) begin
          sel = task_count[trp_pkg::IDX_W-1:0];
          clear_slot(int'(sel));
          r.assigned_index = sel;
          task_count++;
          show = 1'b1;
        end else begin
          r.status = trp_pkg::STATUS_FULL;
        end
      end
      trp_pkg::OP_TICK: begin
        window_us = ev.timestamp;
        for (int i = 0; i < trp_pkg::TASKS; i++) begin
          if (i < task_count) begin
            busy_window[i] = '0;
            c0_count[i]    = '0;
            c1_count[i]    = '0;
          end
        end
        show = known;
      end
      default: begin
        // Switch in, switch out, read and the two spare codes, which read.
        if (known) begin
          show = 1'b1;
          if (ev.operation == trp_pkg::OP_SWITCH_IN) begin
            if (ev.core) c1_count[sel]++;
            else c0_count[sel]++;
            slice_t0[sel] = ev.timestamp;
            on_cpu[sel]   = 1'b1;
          end else if (ev.operation == trp_pkg::OP_SWITCH_OUT) begin
            // The slice is added even when the task was not switched in.
            slice            = ev.timestamp - slice_t0[sel];
            busy_total[sel]  = busy_total[sel] + slice;
            busy_window[sel] = busy_window[sel] + slice[31:0];
            on_cpu[sel]      = 1'b0;
          end
        end else begin
          r.status = trp_pkg::STATUS_BADIDX;
        end
      end
    endcase

    r.registered_count = task_count;
    if (show) begin
      r.total_run_time  = busy_total[sel];
      r.window_run_time = busy_window[sel];
      r.core0_starts    = c0_count[sel];
      r.core1_starts    = c1_count[sel];
      r.is_running      = on_cpu[sel];
    end
    r.total_elapsed  = ev.timestamp - origin_us;
    delta            = ev.timestamp - window_us;
    r.window_elapsed = delta[31:0];
    return r;
  endfunction

  task automatic cmp(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  // Results are compared before a request of the same cycle is predicted, so a
  // result can never be matched against a request that arrives with it.
  always @(posedge clk) begin
    trp_pkg::rsp_t want;
    if (rst) begin
      due_results.delete();
      task_count = '0;
      origin_us  = '0;
      window_us  = '0;
      for (int i = 0; i < trp_pkg::TASKS; i++) clear_slot(i);
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          errs++;
        end else begin
          want = due_results.pop_front();
          cmp("status", 64'(want.status), 64'(out_data.status));
          cmp("assigned_index", 64'(want.assigned_index), 64'(out_data.assigned_index));
          cmp("registered_count", 64'(want.registered_count),
              64'(out_data.registered_count));
          cmp("total_run_time", want.total_run_time, out_data.total_run_time);
          cmp("window_run_time", 64'(want.window_run_time), 64'(out_data.window_run_time));
          cmp("core0_starts", 64'(want.core0_starts), 64'(out_data.core0_starts));
          cmp("core1_starts", 64'(want.core1_starts), 64'(out_data.core1_starts));
          cmp("is_running", 64'(want.is_running), 64'(out_data.is_running));
          cmp("total_elapsed", want.total_elapsed, out_data.total_elapsed);
          cmp("window_elapsed", 64'(want.window_elapsed), 64'(out_data.window_elapsed));
        end
      end
      if (in_valid && in_ready) due_results.push_back(profile_event(in_data));
      pending <= due_results.size();
    end
    mismatches <= errs;
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  // The spare operation codes behave as a read.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int HOLD_CYCLES = 80;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  trp_pkg::req_t in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  trp_pkg::rsp_t out_data;
  int            pending;
  int            mismatches;

  // Stimulus-side bookkeeping.
  int          items        = 0;
  int          regs_sent    = 0;
  logic [63:0] clock_us     = '0;
  bit          idle_on      = 1'b1;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;

  always #4 clk = ~clk;

  task_runtime_profiler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  profiler_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // Offers one request, sometimes after a burst of idle cycles, and waits for it
  // to be taken.
  task automatic issue(input logic [2:0] op, input logic [3:0] idx, input logic cpu,
                       input logic [63:0] ts);
    trp_pkg::req_t r;
    if (idle_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    r.operation  = op;
    r.task_index = idx;
    r.core       = cpu;
    r.timestamp  = ts;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == trp_pkg::OP_REGISTER) regs_sent++;
    items++;
  endtask

  // Mostly a registered task, now and then any index.
  function automatic logic [3:0] pick_task();
    int live;
    live = (regs_sent > trp_pkg::TASKS) ? trp_pkg::TASKS : regs_sent;
    if (live > 0 && $urandom_range(9) != 0) return 4'($urandom_range(live - 1));
    return 4'($urandom_range(15));
  endfunction

  // Time moves forward in small steps, with an occasional jump anywhere.
  function automatic logic [63:0] advance();
    if ($urandom_range(15) == 0) clock_us = {$urandom, $urandom};
    else clock_us = clock_us + 64'($urandom_range(1, 3000));
    return clock_us;
  endfunction

  // Result side: random back-pressure, one long hold when asked, none at the end.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          kind;
    bit          held;
    bit          drained;
    logic [3:0]  t;
    logic [2:0]  op;
    held    = 1'b0;
    drained = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, first registrations, wrap of slices and elapsed times.
    issue(trp_pkg::OP_READ, 4'd15, 1'b0, 64'd0);
    issue(trp_pkg::OP_SWITCH_IN, 4'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(trp_pkg::OP_SWITCH_OUT, 4'd0, 1'b0, 64'd50);
    issue(trp_pkg::OP_START, 4'd0, 1'b0, 64'd100);
    issue(trp_pkg::OP_REGISTER, 4'd9, 1'b1, 64'd110);
    issue(trp_pkg::OP_REGISTER, 4'd0, 1'b0, 64'd120);
    issue(trp_pkg::OP_REGISTER, 4'd15, 1'b0, 64'd130);
    issue(trp_pkg::OP_SWITCH_IN, 4'd0, 1'b0, 64'd200);
    issue(trp_pkg::OP_SWITCH_IN, 4'd1, 1'b1, 64'd210);
    issue(trp_pkg::OP_SWITCH_OUT, 4'd0, 1'b0, 64'd500);
    issue(trp_pkg::OP_SWITCH_OUT, 4'd2, 1'b1, 64'd600);
    issue(OP_SPARE6, 4'd1, 1'b0, 64'd700);
    issue(OP_SPARE7, 4'd0, 1'b1, 64'd700);
    issue(trp_pkg::OP_TICK, 4'd1, 1'b0, 64'd800);
    issue(trp_pkg::OP_SWITCH_OUT, 4'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(trp_pkg::OP_SWITCH_OUT, 4'd1, 1'b1, 64'd5);
    issue(trp_pkg::OP_READ, 4'd3, 1'b0, 64'd900);
    issue(trp_pkg::OP_START, 4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(trp_pkg::OP_READ, 4'd2, 1'b1, 64'd0);
    issue(trp_pkg::OP_SWITCH_IN, 4'd2, 1'b1, 64'h8000_0000_0000_0000);
    issue(trp_pkg::OP_TICK, 4'd5, 1'b1, 64'd1000);
    issue(trp_pkg::OP_READ, 4'd2, 1'b0, 64'd1200);
    clock_us = 64'd1200;

    // Random part: switch-in/switch-out pairs on live tasks are the most common item.
    while (items < 450) begin
      if (!held && items >= 150) begin
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!drained && items >= 300) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (items >= 380) begin
        idle_on = 1'b0;
        quiet   = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 40) begin
        t = pick_task();
        issue(trp_pkg::OP_SWITCH_IN, t, 1'($urandom_range(1)), advance());
        if ($urandom_range(2) == 0) begin
          issue(trp_pkg::OP_READ, t, 1'($urandom_range(1)), advance());
        end
        issue(trp_pkg::OP_SWITCH_OUT, t, 1'($urandom_range(1)), advance());
      end else if (kind < 55) begin
        op = ($urandom_range(3) != 0) ? trp_pkg::OP_READ :
             ($urandom_range(1) ? OP_SPARE6 : OP_SPARE7);
        issue(op, pick_task(), 1'($urandom_range(1)), advance());
      end else if (kind < 63) begin
        issue(trp_pkg::OP_TICK, pick_task(), 1'($urandom_range(1)), advance());
      end else if (kind < 69) begin
        issue(trp_pkg::OP_REGISTER, 4'($urandom_range(15)), 1'($urandom_range(1)),
              advance());
      end else if (kind < 73) begin
        issue(trp_pkg::OP_START, pick_task(), 1'($urandom_range(1)), advance());
      end else begin
        // Noise: any code, any index, any time.
        op = 3'($urandom_range(7));
        issue(op, 4'($urandom_range(15)), 1'($urandom_range(1)), {$urandom, $urandom});
      end
    end

    // Make sure the table fills and one more registration is refused.
    while (regs_sent <= trp_pkg::TASKS) begin
      issue(trp_pkg::OP_REGISTER, 4'($urandom_range(15)), 1'b0, advance());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
